// ----- hw/rtl/itoa_pkg.sv -----
package itoa_pkg;

  localparam int unsigned OperationWidth = 2;
  localparam int unsigned ValueWidth     = 32;
  localparam int unsigned CharWidth      = 8;

  localparam logic [OperationWidth-1:0] OP_SIGNED_DEC   = 2'd0;
  localparam logic [OperationWidth-1:0] OP_UNSIGNED_DEC = 2'd1;
  localparam logic [OperationWidth-1:0] OP_HEX          = 2'd2;

  localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CHAR_A     = 8'h61;
  localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONVERT,
    BK_SKIP,
    BK_SIGN,
    BK_EMIT
  } back_state_e;

  function automatic logic [CharWidth-1:0] digit_to_char(input logic [3:0] digit);
    logic [CharWidth-1:0] c;
    if (digit < 4'd10) begin
      c = CHAR_ZERO + CharWidth'(digit);
    end else begin
      c = CHAR_A + CharWidth'(digit - 4'd10);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/itoa_in_if.sv -----
interface itoa_in_if
  import itoa_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [OperationWidth-1:0] operation;
  logic [ValueWidth-1:0]     value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

// ----- hw/rtl/itoa_out_if.sv -----
interface itoa_out_if
  import itoa_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] character;
  logic                 last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// ----- hw/rtl/itoa_front.sv -----
module itoa_front
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  itoa_in_if.sink                 in_i,
  input  logic                    full_i,
  output logic                    push_o,
  output logic [VALUE_BITS+1:0]   data_o
);

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic                  hex;

  always_comb begin
    raw = VALUE_BITS'(in_i.value);
    neg = 1'b0;
    hex = 1'b0;
    mag = raw;
    case (in_i.operation)
      OP_SIGNED_DEC: begin
        neg = raw[VALUE_BITS-1];
        if (neg) begin
          mag = ~raw + VALUE_BITS'(1);
        end
      end
      OP_HEX: begin
        hex = 1'b1;
      end
      default: begin
        hex = 1'b0;
      end
    endcase
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign data_o     = {hex, neg, mag};

endmodule

// ----- hw/rtl/itoa_fifo.sv -----
module itoa_fifo #(
  parameter int unsigned Width = 34,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == CntWidth'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/itoa_back.sv -----
module itoa_back
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [VALUE_BITS+1:0] data_i,
  output logic                  pop_o,
  itoa_out_if.source            out_o
);

  localparam int unsigned DecDigits = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int unsigned HexDigits = (VALUE_BITS + 3) / 4;
  localparam int unsigned NumDigits = (DecDigits > HexDigits) ? DecDigits : HexDigits;
  localparam int unsigned DigWidth  = NumDigits * 4;
  localparam int unsigned CntWidth  = $clog2(VALUE_BITS + 1);
  localparam int unsigned LeftWidth = $clog2(NumDigits + 1);

  function automatic logic [DigWidth-1:0] dabble_step(input logic [DigWidth-1:0] d,
                                                       input logic b);
    logic [DigWidth-1:0] a;
    a = d;
    for (int i = 0; i < NumDigits; i++) begin
      if (a[i*4 +: 4] >= 4'd5) begin
        a[i*4 +: 4] = a[i*4 +: 4] + 4'd3;
      end
    end
    return {a[DigWidth-2:0], b};
  endfunction

  back_state_e          state_q, state_d;
  logic [VALUE_BITS-1:0] bin_q;
  logic [DigWidth-1:0]   dig_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [LeftWidth-1:0]  left_q;
  logic                  neg_q;
  logic                  out_valid_q;
  logic [CharWidth-1:0]  char_q;
  logic                  last_q;

  logic [3:0]            top_digit;
  logic                  slot_free;
  logic                  in_hex;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  load_item;
  logic                  do_convert;
  logic                  do_skip;
  logic                  load_sign;
  logic                  load_digit;

  assign top_digit = dig_q[DigWidth-1 -: 4];
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_hex    = data_i[VALUE_BITS+1];
  assign in_neg    = data_i[VALUE_BITS];
  assign in_mag    = data_i[VALUE_BITS-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          state_d = in_hex ? BK_SKIP : BK_CONVERT;
        end
      end
      BK_CONVERT: begin
        if (cnt_q == CntWidth'(1)) begin
          state_d = BK_SKIP;
        end
      end
      BK_SKIP: begin
        if (top_digit != 4'd0 || left_q == LeftWidth'(1)) begin
          state_d = neg_q ? BK_SIGN : BK_EMIT;
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free && left_q == LeftWidth'(1)) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    load_item  = 1'b0;
    do_convert = 1'b0;
    do_skip    = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    case (state_q)
      BK_IDLE:    load_item  = valid_i;
      BK_CONVERT: do_convert = 1'b1;
      BK_SKIP:    do_skip    = (top_digit == 4'd0) && (left_q != LeftWidth'(1));
      BK_SIGN:    load_sign  = slot_free;
      BK_EMIT:    load_digit = slot_free;
      default:    load_item  = 1'b0;
    endcase
  end

  assign pop_o = load_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_sign || load_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      neg_q  <= in_neg;
      bin_q  <= in_mag;
      cnt_q  <= CntWidth'(VALUE_BITS);
      left_q <= LeftWidth'(NumDigits);
      dig_q  <= in_hex ? DigWidth'(in_mag) : '0;
    end
    if (do_convert) begin
      dig_q <= dabble_step(dig_q, bin_q[VALUE_BITS-1]);
      bin_q <= bin_q << 1;
      cnt_q <= cnt_q - CntWidth'(1);
    end
    if (do_skip || load_digit) begin
      dig_q  <= dig_q << 4;
      left_q <= left_q - LeftWidth'(1);
    end
    if (load_sign) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end
    if (load_digit) begin
      char_q <= digit_to_char(top_digit);
      last_q <= (left_q == LeftWidth'(1));
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

endmodule

// ----- hw/rtl/integer_to_ascii_digits_unit.sv -----
// Integer to ASCII text converter.
// The input channel carries a format code and a 32-bit value; the output
// channel returns the text one character per transaction, most significant
// character first, with last set on the final character. Formats are signed
// decimal, unsigned decimal and lowercase hexadecimal; the unused code prints
// as unsigned decimal.
// The front stage classifies each transaction and writes it into a two-entry
// queue in the same cycle. The back stage converts one number at a time: it
// loads the number, runs the shift-add-3 steps for decimal and none for
// hexadecimal, drops leading zero digits, then sends the characters, with a
// minus sign first for a negative signed number. It takes the next number
// from the queue only after it has loaded the last character of the current
// one into the output register.
// Reset empties the queue, drops any number in progress and clears the
// output valid flag. When the receiver stalls, the current character holds in
// the output register and the back stage waits before loading the next one;
// the front keeps accepting until the queue is full.
module integer_to_ascii_digits_unit
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);

  localparam int unsigned EntryWidth = VALUE_BITS + 2;

  logic                  fifo_full;
  logic                  fifo_push;
  logic [EntryWidth-1:0] fifo_wdata;
  logic                  fifo_valid;
  logic                  fifo_pop;
  logic [EntryWidth-1:0] fifo_rdata;

  itoa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_i   (in_i),
    .full_i (fifo_full),
    .push_o (fifo_push),
    .data_o (fifo_wdata)
  );

  itoa_fifo #(
    .Width(EntryWidth),
    .Depth(2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_rdata)
  );

  itoa_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fifo_valid),
    .data_i  (fifo_rdata),
    .pop_o   (fifo_pop),
    .out_o   (out_o)
  );

endmodule
